>>> design/v3alu_pkg.sv
// Shared types, constants and the clamp function of the 3-D vector unit.
`default_nettype none

package v3alu_pkg;

    localparam int WORD_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int LANE_W      = PROD_W + 1;
    localparam int SUM_W       = PROD_W + 2;
    localparam int SQ_W        = PROD_W;
    localparam int ROOT_W      = WORD_W;
    localparam int QUO_W       = FRAC_W + 1;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = FRAC_W + 1;
    localparam int IN_W        = 232;
    localparam int OUT_W       = 136;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_SCALE = 3'd2,
        OP_DOT   = 3'd3,
        OP_CROSS = 3'd4,
        OP_LEN   = 3'd5,
        OP_NORM  = 3'd6,
        OP_NONE  = 3'd7
    } op_t;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t value;
        logic  sat;
    } clamp_t;

    // results that travel alongside the root pipeline
    typedef struct packed {
        op_t   op;
        word_t rx;
        word_t ry;
        word_t rz;
        word_t sc;
        logic  sat;
        word_t ax;
        word_t ay;
        word_t az;
    } mid_t;

    // results that travel alongside the divider pipelines
    typedef struct packed {
        op_t   op;
        word_t rx;
        word_t ry;
        word_t rz;
        word_t sc;
        logic  sat;
        logic  len_nz;
    } post_t;

    // clamp a wide signed value to the word range
    function automatic clamp_t clamp_word(input logic signed [SUM_W-1:0] v);
        clamp_t c;
        c.value = v[WORD_W-1:0];
        c.sat   = 1'b0;
        if (!((&v[SUM_W-1:WORD_W-1]) || (~|v[SUM_W-1:WORD_W-1]))) begin
            c.sat   = 1'b1;
            c.value = v[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/v3alu_lane.sv
// One component lane: two multipliers, add/subtract and the lane combine.
`default_nettype none

module v3alu_lane
    import v3alu_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire op_t                      op,
    input  wire word_t                    a_own,
    input  wire word_t                    a_next,
    input  wire word_t                    a_prev,
    input  wire word_t                    b_own,
    input  wire word_t                    b_next,
    input  wire word_t                    b_prev,
    input  wire word_t                    sf,
    output logic signed [LANE_W-1:0]      p,
    output logic signed [PROD_W-1:0]      m1
);

    word_t                      a1, b1;
    op_t                        op_reg;
    logic signed [PROD_W-1:0]   m1_reg, m2_reg, m1_out_reg;
    logic signed [WORD_W:0]     as_reg;
    logic signed [LANE_W-1:0]   p_reg, p_next, diff;

    // operand selection for the main multiplier
    always_comb begin
        a1 = a_own;
        b1 = a_own;
        case (op)
            OP_SCALE: b1 = sf;
            OP_DOT:   b1 = b_own;
            OP_CROSS: begin
                a1 = a_next;
                b1 = b_prev;
            end
            default:  b1 = a_own;
        endcase
    end

    // first stage: products and exact add/subtract
    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg <= op;
            m1_reg <= PROD_W'(a1) * PROD_W'(b1);
            m2_reg <= PROD_W'(a_prev) * PROD_W'(b_next);
            as_reg <= (op == OP_SUB) ? ((WORD_W+1)'(a_own) - (WORD_W+1)'(b_own))
                                     : ((WORD_W+1)'(a_own) + (WORD_W+1)'(b_own));
        end
    end

    // second stage: combine and drop the fraction (floor)
    always_comb begin
        diff = LANE_W'(m1_reg) - LANE_W'(m2_reg);
        case (op_reg) inside
            OP_ADD, OP_SUB: p_next = LANE_W'(as_reg);
            OP_SCALE:       p_next = LANE_W'(m1_reg) >>> FRAC_W;
            OP_CROSS:       p_next = diff >>> FRAC_W;
            default:        p_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg      <= p_next;
            m1_out_reg <= m1_reg;
        end
    end

    assign p  = p_reg;
    assign m1 = m1_out_reg;

endmodule

`default_nettype wire

>>> design/v3alu_sqrt.sv
// Pipelined floor integer square root, one root bit per stage.
`default_nettype none

module v3alu_sqrt
    import v3alu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [SQ_W-1:0]   n_in,
    output logic [ROOT_W-1:0]      root
);

    localparam int REM_W = ROOT_W + 3;

    logic [REM_W-1:0]   rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0]  root_reg [SQRT_STAGES];
    logic [SQ_W-1:0]    n_reg    [SQRT_STAGES];
    logic [REM_W-1:0]   rem_next [SQRT_STAGES];
    logic [ROOT_W-1:0]  root_next[SQRT_STAGES];
    logic [SQ_W-1:0]    n_next   [SQRT_STAGES];

    // one trial subtract per stage
    always_comb begin
        logic [REM_W-1:0]  r_in, t, trial;
        logic [ROOT_W-1:0] q_in;
        logic [SQ_W-1:0]   n_cur;
        for (int k = 0; k < SQRT_STAGES; k++) begin
            if (k == 0) begin
                r_in  = '0;
                q_in  = '0;
                n_cur = n_in;
            end else begin
                r_in  = rem_reg[k-1];
                q_in  = root_reg[k-1];
                n_cur = n_reg[k-1];
            end
            t     = {r_in[REM_W-3:0], n_cur[SQ_W-1:SQ_W-2]};
            trial = {1'b0, q_in, 2'b01};
            if (t >= trial) begin
                rem_next[k]  = t - trial;
                root_next[k] = {q_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = t;
                root_next[k] = {q_in[ROOT_W-2:0], 1'b0};
            end
            n_next[k] = {n_cur[SQ_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                n_reg[k]    <= n_next[k];
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

`default_nettype wire

>>> design/v3alu_div.sv
// Pipelined restoring divider for one normalise component, one quotient bit per stage.
`default_nettype none

module v3alu_div
    import v3alu_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire logic [WORD_W-1:0]   mag,
    input  wire logic [WORD_W-1:0]   len,
    input  wire logic                neg,
    output word_t                    q
);

    logic [WORD_W-1:0]  rem_reg [DIV_STAGES];
    logic [QUO_W-1:0]   quo_reg [DIV_STAGES];
    logic [WORD_W-1:0]  len_reg [DIV_STAGES];
    logic               neg_reg [DIV_STAGES];
    logic [WORD_W-1:0]  rem_next[DIV_STAGES];
    logic [QUO_W-1:0]   quo_next[DIV_STAGES];
    logic [QUO_W-1:0]   quo_last;

    // magnitude never exceeds the length, so the quotient is at most one
    always_comb begin
        logic [WORD_W:0]    t;
        logic               ge;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                t  = {1'b0, mag};
                ge = t >= {1'b0, len};
                rem_next[k] = ge ? (mag - len) : mag;
                quo_next[k] = {{(QUO_W-1){1'b0}}, ge};
            end else begin
                t  = {rem_reg[k-1], 1'b0};
                ge = t >= {1'b0, len_reg[k-1]};
                rem_next[k] = ge ? WORD_W'(t - {1'b0, len_reg[k-1]}) : t[WORD_W-1:0];
                quo_next[k] = {quo_reg[k-1][QUO_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= rem_next[0];
            quo_reg[0] <= quo_next[0];
            len_reg[0] <= len;
            neg_reg[0] <= neg;
            for (int k = 1; k < DIV_STAGES; k++) begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                len_reg[k] <= len_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    // truncation toward zero: negate the magnitude quotient
    assign quo_last = quo_reg[DIV_STAGES-1];
    assign q = neg_reg[DIV_STAGES-1] ? -word_t'({{(WORD_W-QUO_W){1'b0}}, quo_last})
                                     : word_t'({{(WORD_W-QUO_W){1'b0}}, quo_last});

endmodule

`default_nettype wire

>>> design/vec3_fixed_point_alu_unit.sv
// Top level of the 3-D Q16.16 vector unit: lanes, root, dividers and merge.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata: action, ax..bz, scale_factor
//  m_       | out | m_tvalid/m_tready  | m_tdata: rx, ry, rz, scalar_out, saturated
//
// One request per cycle is taken while the output is not stalled; every operation
// passes through the 32-stage square root and the 17-stage normalise dividers.
// aresetn (synchronous, active low) clears only the valid pipeline.
// A stalled output freezes the whole pipeline; s_tready follows that stall.
`default_nettype none

module vec3_fixed_point_alu_unit
    import v3alu_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // action[2:0], ax[34:3], ay[66:35], az[98:67], bx[130:99], by[162:131],
    // bz[194:163], scale_factor[226:195], zero pad
    input  wire logic [IN_W-1:0]    s_tdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // rx[31:0], ry[63:32], rz[95:64], scalar_out[127:96], saturated[128], zero pad
    output logic [OUT_W-1:0]        m_tdata
);

    localparam int PIPE_LEN = 3 + SQRT_STAGES + DIV_STAGES + 1;

    op_t    s_op;
    word_t  s_ax, s_ay, s_az, s_bx, s_by, s_bz, s_sf;
    logic   en;

    logic                       vld_reg [PIPE_LEN];
    op_t                        op1_reg, op2_reg;
    word_t                      a1_reg [3];
    word_t                      a2_reg [3];
    logic signed [LANE_W-1:0]   px, py, pz;
    logic signed [PROD_W-1:0]   m1x, m1y, m1z;

    logic signed [SUM_W-1:0]    dotsum;
    clamp_t                     cx, cy, cz, cd;
    mid_t                       s3_next;
    logic [SQ_W-1:0]            sq_reg;
    mid_t                       mid_reg [SQRT_STAGES+1];
    logic [ROOT_W-1:0]          root;

    mid_t                       md;
    post_t                      post_next;
    post_t                      post_reg [DIV_STAGES];
    logic [WORD_W-1:0]          mag_x, mag_y, mag_z;
    word_t                      qx, qy, qz;

    post_t                      pd;
    op_t                        out_op_reg;
    word_t                      out_rx_reg, out_ry_reg, out_rz_reg, out_sc_reg;
    logic                       out_sat_reg;

    // request unpacking
    assign s_op = op_t'(s_tdata[2:0]);
    assign s_ax = s_tdata[34:3];
    assign s_ay = s_tdata[66:35];
    assign s_az = s_tdata[98:67];
    assign s_bx = s_tdata[130:99];
    assign s_by = s_tdata[162:131];
    assign s_bz = s_tdata[194:163];
    assign s_sf = s_tdata[226:195];

    // whole pipeline moves unless a finished result is held
    assign en       = !vld_reg[PIPE_LEN-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[PIPE_LEN-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PIPE_LEN; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < PIPE_LEN; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    // three component lanes
    v3alu_lane u_lane_x (
        .aclk(aclk), .en(en), .op(s_op),
        .a_own(s_ax), .a_next(s_ay), .a_prev(s_az),
        .b_own(s_bx), .b_next(s_by), .b_prev(s_bz),
        .sf(s_sf), .p(px), .m1(m1x)
    );

    v3alu_lane u_lane_y (
        .aclk(aclk), .en(en), .op(s_op),
        .a_own(s_ay), .a_next(s_az), .a_prev(s_ax),
        .b_own(s_by), .b_next(s_bz), .b_prev(s_bx),
        .sf(s_sf), .p(py), .m1(m1y)
    );

    v3alu_lane u_lane_z (
        .aclk(aclk), .en(en), .op(s_op),
        .a_own(s_az), .a_next(s_ax), .a_prev(s_ay),
        .b_own(s_bz), .b_next(s_bx), .b_prev(s_by),
        .sf(s_sf), .p(pz), .m1(m1z)
    );

    // side copies of the operation and first vector during the lane stages
    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg   <= s_op;
            op2_reg   <= op1_reg;
            a1_reg[0] <= s_ax;
            a1_reg[1] <= s_ay;
            a1_reg[2] <= s_az;
            for (int i = 0; i < 3; i++) a2_reg[i] <= a1_reg[i];
        end
    end

    // merge stage: clamp lane results, dot sum, sum of squares
    always_comb begin
        dotsum = SUM_W'(m1x) + SUM_W'(m1y) + SUM_W'(m1z);
        cx     = clamp_word(SUM_W'(px));
        cy     = clamp_word(SUM_W'(py));
        cz     = clamp_word(SUM_W'(pz));
        cd     = clamp_word(dotsum >>> FRAC_W);

        s3_next     = '0;
        s3_next.op  = op2_reg;
        s3_next.ax  = a2_reg[0];
        s3_next.ay  = a2_reg[1];
        s3_next.az  = a2_reg[2];
        case (op2_reg) inside
            OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
                s3_next.rx  = cx.value;
                s3_next.ry  = cy.value;
                s3_next.rz  = cz.value;
                s3_next.sat = cx.sat | cy.sat | cz.sat;
            end
            OP_DOT: begin
                s3_next.sc  = cd.value;
                s3_next.sat = cd.sat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mid_reg[0] <= s3_next;
            sq_reg     <= dotsum[SQ_W-1:0];
            for (int k = 1; k <= SQRT_STAGES; k++) mid_reg[k] <= mid_reg[k-1];
        end
    end

    v3alu_sqrt u_sqrt (
        .aclk(aclk), .en(en), .n_in(sq_reg), .root(root)
    );

    // length result and divider set-up
    assign md    = mid_reg[SQRT_STAGES];
    assign mag_x = md.ax[WORD_W-1] ? (~md.ax + 1'b1) : md.ax;
    assign mag_y = md.ay[WORD_W-1] ? (~md.ay + 1'b1) : md.ay;
    assign mag_z = md.az[WORD_W-1] ? (~md.az + 1'b1) : md.az;

    always_comb begin
        post_next        = '0;
        post_next.op     = md.op;
        post_next.rx     = md.rx;
        post_next.ry     = md.ry;
        post_next.rz     = md.rz;
        post_next.sc     = md.sc;
        post_next.sat    = md.sat;
        post_next.len_nz = |root;
        if (md.op == OP_LEN) begin
            post_next.sat = root[ROOT_W-1];
            post_next.sc  = root[ROOT_W-1] ? {1'b0, {(WORD_W-1){1'b1}}} : word_t'(root);
        end
    end

    v3alu_div u_div_x (
        .aclk(aclk), .en(en), .mag(mag_x), .len(root), .neg(md.ax[WORD_W-1]), .q(qx)
    );
    v3alu_div u_div_y (
        .aclk(aclk), .en(en), .mag(mag_y), .len(root), .neg(md.ay[WORD_W-1]), .q(qy)
    );
    v3alu_div u_div_z (
        .aclk(aclk), .en(en), .mag(mag_z), .len(root), .neg(md.az[WORD_W-1]), .q(qz)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            post_reg[0] <= post_next;
            for (int k = 1; k < DIV_STAGES; k++) post_reg[k] <= post_reg[k-1];
        end
    end

    // output register: normalise quotients or the carried results
    assign pd = post_reg[DIV_STAGES-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            out_op_reg  <= pd.op;
            out_sc_reg  <= pd.sc;
            out_sat_reg <= pd.sat;
            if (pd.op == OP_NORM) begin
                out_rx_reg <= pd.len_nz ? qx : '0;
                out_ry_reg <= pd.len_nz ? qy : '0;
                out_rz_reg <= pd.len_nz ? qz : '0;
            end else begin
                out_rx_reg <= pd.rx;
                out_ry_reg <= pd.ry;
                out_rz_reg <= pd.rz;
            end
        end
    end

    assign m_tdata = {7'b0, out_sat_reg, out_sc_reg, out_rz_reg, out_ry_reg, out_rx_reg};

    // a normalised x component never exceeds one in magnitude and never saturates
    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_op_reg == OP_NORM) |->
            (!out_sat_reg && out_rx_reg <= 32'sd65536 && out_rx_reg >= -32'sd65536))
        else $error("normalise result out of range");

    // scalar operations leave the vector at zero
    a_scalar_vec_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_op_reg == OP_DOT || out_op_reg == OP_LEN)) |->
            (out_rx_reg == '0 && out_ry_reg == '0 && out_rz_reg == '0))
        else $error("scalar operation gave a non-zero vector");

    // vector operations leave the scalar at zero
    a_vec_scalar_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_op_reg == OP_ADD || out_op_reg == OP_SUB ||
                      out_op_reg == OP_SCALE || out_op_reg == OP_CROSS ||
                      out_op_reg == OP_NORM)) |-> (out_sc_reg == '0))
        else $error("vector operation gave a non-zero scalar");

endmodule

`default_nettype wire

>>> test/tb_vec3_fixed_point_alu_unit.sv
// Self-checking testbench of the 3-D Q16.16 vector unit: directed table, then random requests.
`default_nettype none

module tb_vec3_fixed_point_alu_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import v3alu_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int N_RANDOM     = 1800;
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic [31:0] sf;
        logic [31:0] bz;
        logic [31:0] by;
        logic [31:0] bx;
        logic [31:0] az;
        logic [31:0] ay;
        logic [31:0] ax;
        op_t         op;
    } vec_req_t;

    typedef struct packed {
        logic        sat;
        logic [31:0] sc;
        logic [31:0] rz;
        logic [31:0] ry;
        logic [31:0] rx;
    } vec_res_t;

    // directed row: request plus optional hand-typed answer
    typedef struct {
        vec_req_t req;
        bit       typed;
        vec_res_t res;
    } row_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    vec_res_t pending_results[$];
    int       fail_count = 0;
    int       cycle_count = 0;
    int       send_idle_pct;
    int       recv_stall_pct;
    bit       hold_off;

    vec3_fixed_point_alu_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // clamp to the signed word, noting overflow
    function automatic logic [31:0] sat_word(input logic signed [127:0] v, inout logic sat);
        if (v > 128'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sd2147483648) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // floor integer square root by bit search
    function automatic logic [63:0] floor_root(input logic [127:0] n);
        logic [63:0]  r;
        logic [127:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = {64'd0, r | (64'd1 << b)};
            if (t * t <= n) r = r | (64'd1 << b);
        end
        return r;
    endfunction

    // truncating divide of c*2^16 by the length
    function automatic logic signed [127:0] unit_div(input logic signed [127:0] c,
                                                      input logic [63:0] len);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (c < 0) ? -c : c;
        q = (mag << FRAC_W) / {64'd0, len};
        return (c < 0) ? -$signed(q) : $signed(q);
    endfunction

    // expected output of one request
    function automatic vec_res_t vec_alu_predict(input vec_req_t q);
        logic signed [127:0] ax, ay, az, bx, by, bz, sf, x, y, z, s;
        logic [127:0]        sq;
        logic [63:0]         len;
        vec_res_t            r;
        logic                sat;
        ax = $signed(q.ax); ay = $signed(q.ay); az = $signed(q.az);
        bx = $signed(q.bx); by = $signed(q.by); bz = $signed(q.bz);
        sf = $signed(q.sf);
        x = 0; y = 0; z = 0; s = 0; sat = 1'b0;
        case (q.op) inside
            OP_ADD: begin
                x = ax + bx; y = ay + by; z = az + bz;
            end
            OP_SUB: begin
                x = ax - bx; y = ay - by; z = az - bz;
            end
            OP_SCALE: begin
                x = (ax * sf) >>> FRAC_W; y = (ay * sf) >>> FRAC_W; z = (az * sf) >>> FRAC_W;
            end
            OP_DOT: s = (ax * bx + ay * by + az * bz) >>> FRAC_W;
            OP_CROSS: begin
                x = (ay * bz - az * by) >>> FRAC_W;
                y = (az * bx - ax * bz) >>> FRAC_W;
                z = (ax * by - ay * bx) >>> FRAC_W;
            end
            OP_LEN, OP_NORM: begin
                sq  = ax * ax + ay * ay + az * az;
                len = floor_root(sq);
                if (q.op == OP_LEN) s = $signed({64'd0, len});
                else if (len != 0) begin
                    x = unit_div(ax, len); y = unit_div(ay, len); z = unit_div(az, len);
                end
            end
            default: ;
        endcase
        r.rx = sat_word(x, sat);
        r.ry = sat_word(y, sat);
        r.rz = sat_word(z, sat);
        r.sc = sat_word(s, sat);
        r.sat = sat;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff - $urandom_range(0, 3);
            1: return 32'h80000000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 8) - 4;
            3: return $urandom_range(0, 32'h0003ffff) - 32'h00020000;
            default: return $urandom;
        endcase
    endfunction

    function automatic vec_req_t rand_req();
        vec_req_t q;
        q.op = op_t'($urandom_range(0, 15) == 0 ? 7 : $urandom_range(0, 6));
        q.ax = rand_word(); q.ay = rand_word(); q.az = rand_word();
        q.bx = rand_word(); q.by = rand_word(); q.bz = rand_word();
        q.sf = rand_word();
        // some 2-D vectors
        if ($urandom_range(0, 7) == 0) begin
            q.az = '0; q.bz = '0;
        end
        return q;
    endfunction

    function automatic vec_req_t mk(input op_t op, input logic [31:0] a, input logic [31:0] b,
                                    input logic [31:0] sf);
        vec_req_t q;
        q.op = op; q.ax = a; q.ay = a; q.az = a; q.bx = b; q.by = b; q.bz = b; q.sf = sf;
        return q;
    endfunction

    // offer one request, idling at the sender rate, until accepted
    task automatic send_req(input vec_req_t q, input bit typed, input vec_res_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - $bits(vec_req_t)){1'b0}}, q};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(typed ? want : vec_alu_predict(q));
    endtask

    // receiver stall and hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        vec_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(vec_res_t)-1:0];
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.rx != want.rx) begin
                    $error("rx expected %h got %h", want.rx, got.rx); fail_count++;
                end
                if (got.ry != want.ry) begin
                    $error("ry expected %h got %h", want.ry, got.ry); fail_count++;
                end
                if (got.rz != want.rz) begin
                    $error("rz expected %h got %h", want.rz, got.rz); fail_count++;
                end
                if (got.sc != want.sc) begin
                    $error("scalar_out expected %h got %h", want.sc, got.sc); fail_count++;
                end
                if (got.sat != want.sat) begin
                    $error("saturated expected %b got %b", want.sat, got.sat); fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_vec3_fixed_point_alu_unit NOT OK");
            $finish;
        end
    end

    // long receiver hold-off counted here, sender keeps offering back to back
    initial begin
        hold_off = 1'b0;
        wait (cycle_count == 300);
        hold_off = 1'b1;
        repeat (300) @(posedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        row_t     rows[$];
        row_t     rw;
        vec_res_t z;
        int       phase;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        aresetn        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        z = '0;

        // directed table
        rw.typed = 1'b1;
        rw.req = mk(OP_ADD, 32'h7fffffff, 32'h7fffffff, 0);
        rw.res = '{sat: 1, sc: 0, rz: 32'h7fffffff, ry: 32'h7fffffff, rx: 32'h7fffffff};
        rows.push_back(rw);
        rw.req = mk(OP_ADD, 32'h80000000, 32'h80000000, 0);
        rw.res = '{sat: 1, sc: 0, rz: 32'h80000000, ry: 32'h80000000, rx: 32'h80000000};
        rows.push_back(rw);
        rw.req = mk(OP_SUB, 32'h80000000, 32'h00000001, 0);
        rw.res = '{sat: 1, sc: 0, rz: 32'h80000000, ry: 32'h80000000, rx: 32'h80000000};
        rows.push_back(rw);
        rw.req = mk(OP_NORM, 0, 32'h12345678, 32'h0);
        rw.res = z;
        rows.push_back(rw);
        rw.req = mk(OP_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        rw.res = z;
        rows.push_back(rw);
        rw.req = mk(OP_LEN, 0, 0, 0);
        rw.res = z;
        rows.push_back(rw);
        rw.typed = 1'b0;
        rw.req = mk(OP_SCALE, 32'h00030000, 0, 32'hfffe8000);          rows.push_back(rw);
        rw.req = mk(OP_SCALE, 32'h7fffffff, 0, 32'h7fffffff);          rows.push_back(rw);
        rw.req = mk(OP_SCALE, 32'hffffffff, 0, 32'h00000001);          rows.push_back(rw);
        rw.req = mk(OP_DOT, 32'h80000000, 32'h80000000, 0);            rows.push_back(rw);
        rw.req = mk(OP_DOT, 32'h00010000, 32'hffff0000, 0);            rows.push_back(rw);
        rw.req = mk(OP_CROSS, 32'h7fffffff, 32'h80000000, 0);          rows.push_back(rw);
        rw.req = '{op: OP_CROSS, ax: 32'h10000, ay: 0, az: 0, bx: 0, by: 32'h10000, bz: 0,
                   sf: 0};                                              rows.push_back(rw);
        rw.req = mk(OP_LEN, 32'h80000000, 0, 0);                       rows.push_back(rw);
        rw.req = mk(OP_LEN, 32'h7fffffff, 0, 0);                       rows.push_back(rw);
        rw.req = '{op: OP_NORM, ax: 32'h30000, ay: 32'h40000, az: 0, bx: 0, by: 0, bz: 0,
                   sf: 0};                                              rows.push_back(rw);
        rw.req = '{op: OP_NORM, ax: 1, ay: 0, az: 0, bx: 0, by: 0, bz: 0, sf: 0};
        rows.push_back(rw);
        rw.req = mk(OP_NORM, 32'h80000000, 0, 0);                      rows.push_back(rw);
        rw.req = mk(OP_NORM, 32'hffffffff, 0, 0);                      rows.push_back(rw);
        rw.req = mk(OP_ADD, 32'hffffffff, 32'h00000001, 0);            rows.push_back(rw);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].res);

        // random requests over the idling phases
        for (int n = 0; n < N_RANDOM; n++) begin
            phase = n / (N_RANDOM / 5);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                3: begin send_idle_pct = 17; recv_stall_pct = 17; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            // sender pause until the pipeline has drained
            if (n == N_RANDOM / 2) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_results.size() != 0);
            end
            send_req(rand_req(), 1'b0, z);
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_vec3_fixed_point_alu_unit OK");
        end else begin
            $display("tb_vec3_fixed_point_alu_unit NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
design/v3alu_pkg.sv
design/v3alu_lane.sv
design/v3alu_sqrt.sv
design/v3alu_div.sv
design/vec3_fixed_point_alu_unit.sv
test/tb_vec3_fixed_point_alu_unit.sv
